@@ hdl/kiss_random_bit_pool_top_macros.svh @@
// Assertion macros used by the random bit pool top level.
`ifndef KISS_RANDOM_BIT_POOL_TOP_MACROS_SVH
`define KISS_RANDOM_BIT_POOL_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define KBP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("random bit pool check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define KBP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("random bit pool check failed");

`endif

@@ hdl/kbp_pkg.sv @@
// Types and constants of the random bit pool.
package kbp_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned COUNT_W = 6;

   localparam logic [WORD_W-1:0] WEYL_STEP = 32'd1411392427;
   localparam logic [WORD_W-1:0] LAG_MASK = 32'd2147483647;
   localparam int unsigned XS_SHIFT_A = 5;
   localparam int unsigned XS_SHIFT_B = 7;
   localparam int unsigned XS_SHIFT_C = 22;

   localparam logic [WORD_W-1:0] SEED_WEYL_RESET = 32'd123456789;
   localparam logic [WORD_W-1:0] SEED_XS_RESET = 32'd362436069;
   localparam logic [WORD_W-1:0] SEED_LAG_FIRST_RESET = 32'd521288629;
   localparam logic [WORD_W-1:0] SEED_LAG_SECOND_RESET = 32'd916191069;

   localparam logic [COUNT_W-1:0] MAX_BITS = 6'd32;

   typedef enum logic [1:0] {
      REG_SEED_WEYL,
      REG_SEED_XORSHIFT,
      REG_SEED_LAG_FIRST,
      REG_SEED_LAG_SECOND
   } reg_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] weyl;
      logic [WORD_W-1:0] xorshift;
      logic [WORD_W-1:0] lag_first;
      logic [WORD_W-1:0] lag_second;
   } seed_set_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_GEN,
      ST_STORE,
      ST_FETCH,
      ST_DONE
   } state_type;

endpackage

@@ hdl/kbp_gen.sv @@
// Generator of the random bit pool: xorshift, add-with-carry lag pair and Weyl counter.
module kbp_gen (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic                     step,
   input  kbp_pkg::seed_set_type    seeds,
   output logic [kbp_pkg::WORD_W-1:0] word
);
   import kbp_pkg::*;

   logic [WORD_W-1:0] weyl_ff, weyl_in;
   logic [WORD_W-1:0] xs_ff, xs_in;
   logic [WORD_W-1:0] older_ff, older_in;
   logic [WORD_W-1:0] newer_ff, newer_in;
   logic              carry_ff, carry_in;

   logic [WORD_W-1:0] xs_a, xs_b, xs_c;
   logic [WORD_W-1:0] lag_sum;

   always_comb begin
      xs_a = xs_ff ^ (xs_ff << XS_SHIFT_A);
      xs_b = xs_a ^ (xs_a >> XS_SHIFT_B);
      xs_c = xs_b ^ (xs_b << XS_SHIFT_C);
      lag_sum = older_ff + newer_ff + {{(WORD_W-1){1'b0}}, carry_ff};
   end

   always_comb begin
      weyl_in = weyl_ff;
      xs_in = xs_ff;
      older_in = older_ff;
      newer_in = newer_ff;
      carry_in = carry_ff;
      if (load) begin
         weyl_in = seeds.weyl;
         xs_in = seeds.xorshift;
         older_in = seeds.lag_first;
         newer_in = seeds.lag_second;
         carry_in = 1'b0;
      end else if (step) begin
         weyl_in = weyl_ff + WEYL_STEP;
         xs_in = xs_c;
         older_in = newer_ff;
         newer_in = lag_sum & LAG_MASK;
         carry_in = lag_sum[WORD_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weyl_ff <= SEED_WEYL_RESET;
         xs_ff <= SEED_XS_RESET;
         older_ff <= SEED_LAG_FIRST_RESET;
         newer_ff <= SEED_LAG_SECOND_RESET;
         carry_ff <= 1'b0;
      end else begin
         weyl_ff <= weyl_in;
         xs_ff <= xs_in;
         older_ff <= older_in;
         newer_ff <= newer_in;
         carry_ff <= carry_in;
      end
   end

   assign word = weyl_ff + xs_ff + newer_ff;

endmodule

@@ hdl/kiss_random_bit_pool_top.sv @@
// Top level of the random bit pool: seed registers, pool memory and draw sequencer.
//
//   Port group   Handshake              Content
//   req_*        req_valid/req_stall    req_bit_count, bits to draw (above 32 means 32)
//   rsp_*        rsp_valid/rsp_stall    rsp_random_bits, first drawn bit most significant
//   APB          psel/penable/pwrite    four 32-bit seed registers at 0x0, 0x4, 0x8, 0xC
//
// A request draws each bit from a nonzero pool word through ST_SCAN and ST_READ, skips each
// zero word in ST_SCAN, and refills the pool through ST_GEN and ST_STORE per word, then ST_FETCH;
// ST_IDLE accepts it and ST_DONE returns the word. A zero count goes from ST_IDLE straight to
// ST_DONE and returns 0. Reset is synchronous and empties the pool at once.
// No new request is taken until the result word has left through rsp_stall low.
`include "kiss_random_bit_pool_top_macros.svh"

module kiss_random_bit_pool_top #(
   parameter int unsigned POOL_WORDS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [kbp_pkg::COUNT_W-1:0] req_bit_count,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [kbp_pkg::WORD_W-1:0]  rsp_random_bits,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [3:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import kbp_pkg::*;

   localparam int unsigned IDX_W = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
   localparam int unsigned POS_W = $clog2(POOL_WORDS + 1);
   localparam logic [POS_W-1:0] POS_END = POS_W'(POOL_WORDS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_WORDS - 1);

   state_type state_ff, state_in;
   seed_set_type seeds_ff, seeds_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [WORD_W-1:0] result_ff, result_in;
   logic [POOL_WORDS-1:0] nz_ff, nz_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic [WORD_W-1:0] pool_mem [POOL_WORDS];

   logic cfg_write;
   reg_index_type cfg_reg;
   logic [COUNT_W-1:0] req_count;
   logic [IDX_W-1:0] pos_idx;
   logic at_end;
   logic cur_nz;
   logic gen_step;
   logic [WORD_W-1:0] gen_word;
   logic mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_reg = reg_index_type'(paddr[3:2]);

   always_comb begin
      seeds_in = seeds_ff;
      if (cfg_write) begin
         case (cfg_reg)
            REG_SEED_WEYL: begin
               seeds_in.weyl = pwdata;
            end
            REG_SEED_XORSHIFT: begin
               seeds_in.xorshift = pwdata;
            end
            REG_SEED_LAG_FIRST: begin
               seeds_in.lag_first = pwdata;
            end
            REG_SEED_LAG_SECOND: begin
               seeds_in.lag_second = pwdata;
            end
            default: begin
               seeds_in = seeds_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_reg)
         REG_SEED_WEYL: prdata = seeds_ff.weyl;
         REG_SEED_XORSHIFT: prdata = seeds_ff.xorshift;
         REG_SEED_LAG_FIRST: prdata = seeds_ff.lag_first;
         REG_SEED_LAG_SECOND: prdata = seeds_ff.lag_second;
         default: prdata = '0;
      endcase
   end

   kbp_gen u_gen (
      .clock (clock),
      .reset (reset),
      .load  (cfg_write),
      .step  (gen_step),
      .seeds (seeds_in),
      .word  (gen_word)
   );

   assign req_count = (req_bit_count > MAX_BITS) ? MAX_BITS : req_bit_count;
   assign pos_idx = pos_ff[IDX_W-1:0];
   assign at_end = (pos_ff == POS_END);
   assign cur_nz = at_end ? 1'b0 : nz_ff[pos_idx];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_count == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (at_end) begin
               state_in = ST_GEN;
            end else if (cur_nz) begin
               state_in = ST_READ;
            end
         end
         ST_GEN: begin
            state_in = ST_STORE;
         end
         ST_STORE: begin
            state_in = (k_ff == IDX_LAST) ? ST_FETCH : ST_GEN;
         end
         ST_FETCH: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = (cnt_ff == COUNT_W'(1)) ? ST_DONE : ST_SCAN;
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_waddr = pos_idx;
      mem_wdata = rd_data_ff >> 1;
      gen_step = 1'b0;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      k_in = k_ff;
      result_in = result_ff;
      nz_in = nz_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cnt_in = req_count;
               pos_in = '0;
               result_in = '0;
            end
         end
         ST_SCAN: begin
            if (at_end) begin
               k_in = '0;
            end else if (!cur_nz) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         ST_GEN: begin
            gen_step = 1'b1;
         end
         ST_STORE: begin
            mem_we = 1'b1;
            mem_waddr = k_ff;
            mem_wdata = gen_word;
            nz_in[k_ff] = (gen_word != '0);
            k_in = k_ff + IDX_W'(1);
            if (k_ff == IDX_LAST) begin
               pos_in = '0;
            end
         end
         ST_READ: begin
            mem_we = 1'b1;
            nz_in[pos_idx] = (rd_data_ff[WORD_W-1:1] != '0);
            result_in = {result_ff[WORD_W-2:0], rd_data_ff[0]};
            cnt_in = cnt_ff - COUNT_W'(1);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
      if (cfg_write) begin
         nz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pool_mem[mem_waddr] <= mem_wdata;
      end
      if (!at_end) begin
         rd_data_ff <= pool_mem[pos_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nz_ff <= '0;
         seeds_ff <= '{SEED_WEYL_RESET, SEED_XS_RESET, SEED_LAG_FIRST_RESET,
                       SEED_LAG_SECOND_RESET};
      end else begin
         state_ff <= state_in;
         nz_ff <= nz_in;
         seeds_ff <= seeds_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      pos_ff <= pos_in;
      k_ff <= k_in;
      result_ff <= result_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_random_bits = result_ff;

   `KBP_ASSERT_NEXT(a_zero_count_done, req_valid && !req_stall && req_bit_count == '0, rsp_valid)
   `KBP_ASSERT_NOW(a_scan_word_nonzero, state_ff == ST_READ && $past(state_ff) == ST_SCAN, rd_data_ff != '0)
   `KBP_ASSERT_NEXT(a_cfg_clears_pool, cfg_write, nz_ff == '0)
   `KBP_ASSERT_NOW(a_read_has_count, state_ff == ST_READ, cnt_ff != '0)

endmodule

@@ tb/tb_kiss_random_bit_pool_top.sv @@
// Self-checking testbench for the random bit pool top level with a generator and pool predictor.
`timescale 1ns / 100ps

module tb_kiss_random_bit_pool_top;
   import kbp_pkg::*;

   localparam int unsigned POOL_WORDS = 4;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned PHASE_WORDS = 533;

   typedef enum logic {ROW_DRAW, ROW_SEED} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [COUNT_W-1:0] count;
      reg_index_type     index;
      logic [WORD_W-1:0]  value;
      bit                known_ok;
      logic [WORD_W-1:0]  known;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COUNT_W-1:0] req_bit_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [WORD_W-1:0] rsp_random_bits;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   logic [WORD_W-1:0] seed_reg [4];
   logic [WORD_W-1:0] gen_weyl;
   logic [WORD_W-1:0] gen_xorshift;
   logic [WORD_W-1:0] gen_lag_older;
   logic [WORD_W-1:0] gen_lag_newer;
   logic              gen_carry;
   logic [WORD_W-1:0] pool_word [POOL_WORDS];

   logic [WORD_W-1:0] bits_due [$];

   int unsigned req_gap_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned failures = 0;
   int unsigned idle_cycles = 0;
   int unsigned draws_sent = 0;
   int unsigned draws_checked = 0;
   int unsigned saturated_draws = 0;
   int unsigned empty_draws = 0;
   int unsigned refills = 0;
   int unsigned seed_writes = 0;

   plan_row_type directed_plan [0:23] = '{
      '{ROW_DRAW, 6'd0,  REG_SEED_WEYL,       32'h0,        1'b1, 32'h0},
      '{ROW_DRAW, 6'd1,  REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd32, REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd33, REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd63, REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd31, REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd2,  REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_SEED, 6'd0,  REG_SEED_XORSHIFT,   32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd32, REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd32, REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd0,  REG_SEED_WEYL,       32'h0,        1'b1, 32'h0},
      '{ROW_SEED, 6'd0,  REG_SEED_WEYL,       32'hFFFFFFFF, 1'b0, 32'h0},
      '{ROW_SEED, 6'd0,  REG_SEED_LAG_FIRST,  32'hFFFFFFFF, 1'b0, 32'h0},
      '{ROW_SEED, 6'd0,  REG_SEED_LAG_SECOND, 32'hFFFFFFFF, 1'b0, 32'h0},
      '{ROW_SEED, 6'd0,  REG_SEED_XORSHIFT,   32'hFFFFFFFF, 1'b0, 32'h0},
      '{ROW_DRAW, 6'd63, REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd17, REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_SEED, 6'd0,  REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_SEED, 6'd0,  REG_SEED_LAG_FIRST,  32'h0,        1'b0, 32'h0},
      '{ROW_SEED, 6'd0,  REG_SEED_LAG_SECOND, 32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd32, REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd40, REG_SEED_WEYL,       32'h0,        1'b0, 32'h0},
      '{ROW_SEED, 6'd0,  REG_SEED_XORSHIFT,   32'h1,        1'b0, 32'h0},
      '{ROW_DRAW, 6'd8,  REG_SEED_WEYL,       32'h0,        1'b0, 32'h0}
   };

   kiss_random_bit_pool_top #(
      .POOL_WORDS(POOL_WORDS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_bit_count(req_bit_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_random_bits(rsp_random_bits),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void load_generator();
      gen_weyl = seed_reg[REG_SEED_WEYL];
      gen_xorshift = seed_reg[REG_SEED_XORSHIFT];
      gen_lag_older = seed_reg[REG_SEED_LAG_FIRST];
      gen_lag_newer = seed_reg[REG_SEED_LAG_SECOND];
      gen_carry = 1'b0;
      for (int k = 0; k < POOL_WORDS; k++) begin
         pool_word[k] = '0;
      end
   endfunction

   function automatic logic [WORD_W-1:0] next_generator_word();
      logic [WORD_W-1:0] lag_sum;
      gen_xorshift = gen_xorshift ^ (gen_xorshift << XS_SHIFT_A);
      gen_xorshift = gen_xorshift ^ (gen_xorshift >> XS_SHIFT_B);
      gen_xorshift = gen_xorshift ^ (gen_xorshift << XS_SHIFT_C);
      lag_sum = gen_lag_older + gen_lag_newer + {31'd0, gen_carry};
      gen_lag_older = gen_lag_newer;
      gen_carry = lag_sum[WORD_W-1];
      gen_lag_newer = lag_sum & LAG_MASK;
      gen_weyl = gen_weyl + WEYL_STEP;
      return gen_weyl + gen_xorshift + gen_lag_newer;
   endfunction

   function automatic logic [WORD_W-1:0] draw_bits(input logic [COUNT_W-1:0] count);
      int unsigned draws;
      int unsigned pos;
      logic [WORD_W-1:0] result;
      draws = (count > MAX_BITS) ? int'(MAX_BITS) : int'(count);
      pos = 0;
      result = '0;
      for (int n = 0; n < draws; n++) begin
         while (pos < POOL_WORDS && pool_word[pos] == '0) pos++;
         if (pos >= POOL_WORDS) begin
            for (int k = 0; k < POOL_WORDS; k++) begin
               pool_word[k] = next_generator_word();
            end
            refills++;
            pos = 0;
         end
         result = {result[WORD_W-2:0], pool_word[pos][0]};
         pool_word[pos] = pool_word[pos] >> 1;
      end
      return result;
   endfunction

   function automatic logic [COUNT_W-1:0] random_count();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return '0;
      if (pick < 15) return COUNT_W'($urandom_range(33, 63));
      if (pick < 35) return MAX_BITS;
      return COUNT_W'($urandom_range(1, 31));
   endfunction

   function automatic logic [WORD_W-1:0] random_seed();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return $urandom;
   endfunction

   task automatic send_draw(input logic [COUNT_W-1:0] count, input bit known_ok,
                            input logic [WORD_W-1:0] known);
      logic [WORD_W-1:0] predicted;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_bit_count <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = draw_bits(count);
      bits_due.push_back(known_ok ? known : predicted);
      draws_sent++;
      if (count > MAX_BITS) saturated_draws++;
      if (count == '0) empty_draws++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (bits_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_seed(input reg_index_type index, input logic [WORD_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      seed_reg[index] = value;
      load_generator();
      seed_writes++;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic read_seed(input reg_index_type index);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {index, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== seed_reg[index]) begin
         $error("prdata: expected %h, actual %h", seed_reg[index], prdata);
         failures++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_seeds();
      read_seed(REG_SEED_WEYL);
      read_seed(REG_SEED_XORSHIFT);
      read_seed(REG_SEED_LAG_FIRST);
      read_seed(REG_SEED_LAG_SECOND);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      logic [WORD_W-1:0] want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("kiss_random_bit_pool_top test failed");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (bits_due.size() == 0) begin
               $error("random_bits: no word expected, actual %h", rsp_random_bits);
               failures++;
            end else begin
               want = bits_due.pop_front();
               draws_checked++;
               if (rsp_random_bits !== want) begin
                  $error("random_bits: expected %h, actual %h", want, rsp_random_bits);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      seed_reg[REG_SEED_WEYL] = SEED_WEYL_RESET;
      seed_reg[REG_SEED_XORSHIFT] = SEED_XS_RESET;
      seed_reg[REG_SEED_LAG_FIRST] = SEED_LAG_FIRST_RESET;
      seed_reg[REG_SEED_LAG_SECOND] = SEED_LAG_SECOND_RESET;
      load_generator();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      check_seeds();
      req_gap_pct = 10;
      rsp_stall_pct = 30;
      foreach (directed_plan[r]) begin
         if (directed_plan[r].kind == ROW_SEED) begin
            drain();
            write_seed(directed_plan[r].index, directed_plan[r].value);
         end else begin
            send_draw(directed_plan[r].count, directed_plan[r].known_ok,
                      directed_plan[r].known);
         end
      end
      drain();
      check_seeds();

      for (int phase = 0; phase < 3; phase++) begin
         req_gap_pct = (phase == 0) ? 10 : (phase == 1) ? 80 : 0;
         rsp_stall_pct = (phase == 0) ? 80 : (phase == 1) ? 10 : 0;
         drain();
         write_seed(REG_SEED_WEYL, random_seed());
         write_seed(REG_SEED_XORSHIFT, random_seed());
         write_seed(REG_SEED_LAG_FIRST, random_seed());
         write_seed(REG_SEED_LAG_SECOND, random_seed());
         check_seeds();
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if ($urandom_range(0, 119) == 0) begin
               drain();
               write_seed(reg_index_type'($urandom_range(0, 3)), random_seed());
            end else if ($urandom_range(0, 63) == 0) begin
               drain();
            end
            send_draw(random_count(), 1'b0, '0);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (bits_due.size() != 0) begin
         $error("random_bits: %0d words never returned", bits_due.size());
         failures++;
      end
      $display("Covered %0d draws (%0d checked, %0d saturated, %0d empty) with %0d pool refills,",
               draws_sent, draws_checked, saturated_draws, empty_draws, refills);
      $display("across %0d seed writes and three stall patterns on both channels.", seed_writes);
      if (failures == 0) begin
         $display("kiss_random_bit_pool_top test passed");
      end else begin
         $display("kiss_random_bit_pool_top test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/kbp_pkg.sv
hdl/kbp_gen.sv
hdl/kiss_random_bit_pool_top.sv
tb/tb_kiss_random_bit_pool_top.sv
